/* rtl/fbsb_pkg.sv */
// ----------------------------------------------------------------------------
// fbsb_pkg: shared definitions for the sprite blitter
// Store geometry, operation codes, register indexes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fbsb_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int COLOR_W     = 16;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int AREA_W  = ADDR_W + 1;
  localparam int FW_W    = $clog2(MAX_WIDTH + 1);
  localparam int FH_W    = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [COLOR_W-1:0] RESET_COLOR = COLOR_W'(16'hFFFF);

  typedef enum logic [1:0] {
    FUNC_FILL  = 2'd0,
    FUNC_BEGIN = 2'd1,
    FUNC_PIXEL = 2'd2,
    FUNC_QUERY = 2'd3
  } fbsb_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } fbsb_reg_t;

  typedef struct packed {
    logic clear_wr;   // write reset values at the sweep counter
    logic fill_wr;    // write the fill colour at the sweep counter
    logic ld_in;      // capture the accepted input word
    logic ld_sprite;  // latch origin and size, rewind the cursor
    logic pix_step;   // clip test and cursor advance
    logic pix_wr;     // write the sprite pixel if it landed
    logic q_cmp;      // compare, record and capture the query result
    logic load_out;   // move the result into the output register
  } fbsb_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic fill_done;
    logic out_free;
  } fbsb_status_t;

endpackage

/* rtl/fbsb_ram.sv */
// ----------------------------------------------------------------------------
// fbsb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/fbsb_ctrl.sv */
// ----------------------------------------------------------------------------
// fbsb_ctrl: operation sequencer
// Runs the clearing pass, then steps each accepted word through its states.
// ----------------------------------------------------------------------------
module fbsb_ctrl import fbsb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [1:0]   in_func,
  output logic         in_ready,
  input  fbsb_status_t st,
  output fbsb_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_PIX_CALC,
    S_PIX_WR,
    S_Q_RD,
    S_Q_CMP,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (st.clear_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clear_wr = 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.ld_in = 1'b1;
          unique case (fbsb_func_t'(in_func))
            FUNC_FILL:  state_nxt = S_FILL;
            FUNC_BEGIN: begin
              cmd.ld_sprite = 1'b1;
              state_nxt     = S_RESP;
            end
            FUNC_PIXEL: state_nxt = S_PIX_CALC;
            FUNC_QUERY: state_nxt = S_Q_RD;
          endcase
        end
      end
      S_FILL: begin
        if (st.fill_done) begin
          state_nxt = S_RESP;
        end else begin
          cmd.fill_wr = 1'b1;
        end
      end
      S_PIX_CALC: begin
        cmd.pix_step = 1'b1;
        state_nxt    = S_PIX_WR;
      end
      S_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        state_nxt  = S_RESP;
      end
      S_Q_RD: begin
        state_nxt = S_Q_CMP;
      end
      S_Q_CMP: begin
        cmd.q_cmp = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/fbsb_dp.sv */
// ----------------------------------------------------------------------------
// fbsb_dp: blitter datapath
// Configuration registers, both frame memories, sprite cursor, clipping and
// the output register.
// ----------------------------------------------------------------------------
module fbsb_dp import fbsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fbsb_cmd_t             cmd,
  output fbsb_status_t          st,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [COLOR_W-1:0]    in_pixel_color,
  input  logic [15:0]           in_sprite_col,
  input  logic [15:0]           in_sprite_row,
  input  logic [15:0]           in_sprite_height,
  input  logic [15:0]           in_sprite_width,
  input  logic [ADDR_W-1:0]     in_pixel_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_dirty,
  output logic [COLOR_W-1:0]    out_color_out,
  output logic                  out_written
);

  // Configuration and derived frame size.
  logic [FW_W-1:0]   frame_width_r;
  logic [FH_W-1:0]   frame_height_r;
  logic [FW_W-1:0]   fw;
  logic [FH_W-1:0]   fh;
  logic [AREA_W-1:0] area_r;

  // Captured input word and sweep counter.
  logic [COLOR_W-1:0] color_r;
  logic [ADDR_W-1:0]  idx_r;
  logic [AREA_W-1:0]  cnt_r;

  // Sprite state.
  logic [15:0] origin_col_r, origin_row_r, blit_w_r, blit_h_r;
  logic [15:0] cur_col_r, cur_row_r;
  logic [COL_W-1:0] pix_x_r;
  logic [ROW_W-1:0] pix_y_r;

  // Pending result and output register.
  logic               res_dirty_r, res_written_r;
  logic [COLOR_W-1:0] res_color_r;
  logic               out_valid_r, out_dirty_r, out_written_r;
  logic [COLOR_W-1:0] out_color_r;

  // Memory ports.
  logic               fr_we, pv_we;
  logic [ADDR_W-1:0]  fr_waddr, pv_waddr;
  logic [COLOR_W-1:0] fr_wdata, pv_wdata, fr_rdata, pv_rdata;

  logic [17:0] pos_x, pos_y;
  logic        active, hit, col_wrap, q_ok;
  logic [16:0] col_inc;
  logic [ROW_W+FW_W-1:0] row_base;
  logic [ADDR_W-1:0]     pix_addr;

  assign fw = (frame_width_r > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : frame_width_r;
  assign fh = (frame_height_r > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(MAX_WIDTH);
      frame_height_r <= FH_W'(MAX_HEIGHT);
      area_r         <= AREA_W'(STORE_DEPTH);
    end else begin
      if (cfg_valid) begin
        unique case (fbsb_reg_t'(cfg_index))
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        endcase
      end
      area_r <= AREA_W'(fw) * AREA_W'(fh);
    end
  end

  // Clip test on the current cursor position.
  assign pos_x    = {{2{origin_col_r[15]}}, origin_col_r} + {2'b00, cur_col_r};
  assign pos_y    = {{2{origin_row_r[15]}}, origin_row_r} + {2'b00, cur_row_r};
  assign active   = (blit_w_r != '0) && (cur_row_r < blit_h_r);
  assign hit      = active && !pos_x[17] && !pos_y[17]
                    && (pos_x[16:0] < 17'(fw)) && (pos_y[16:0] < 17'(fh));
  assign col_inc  = {1'b0, cur_col_r} + 17'd1;
  assign col_wrap = col_inc >= {1'b0, blit_w_r};

  assign row_base = (ROW_W+FW_W)'(pix_y_r) * (ROW_W+FW_W)'(fw);
  assign pix_addr = ADDR_W'(row_base + (ROW_W+FW_W)'(pix_x_r));

  assign q_ok = {1'b0, idx_r} < area_r;

  assign st.clear_done = (cnt_r == AREA_W'(STORE_DEPTH));
  assign st.fill_done  = (cnt_r >= area_r);
  assign st.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      origin_col_r  <= '0;
      origin_row_r  <= '0;
      blit_w_r      <= '0;
      blit_h_r      <= '0;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      res_dirty_r   <= 1'b0;
      res_written_r <= 1'b0;
      res_color_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.ld_in) begin
        cnt_r         <= '0;
        res_dirty_r   <= 1'b0;
        res_written_r <= 1'b0;
        res_color_r   <= '0;
      end else if (cmd.clear_wr || cmd.fill_wr) begin
        cnt_r <= cnt_r + AREA_W'(1);
      end
      if (cmd.ld_sprite) begin
        origin_col_r <= in_sprite_col;
        origin_row_r <= in_sprite_row;
        blit_h_r     <= in_sprite_height;
        blit_w_r     <= in_sprite_width;
        cur_col_r    <= '0;
        cur_row_r    <= '0;
      end
      if (cmd.pix_step) begin
        res_written_r <= hit;
        if (active) begin
          if (col_wrap) begin
            cur_col_r <= '0;
            cur_row_r <= cur_row_r + 16'd1;
          end else begin
            cur_col_r <= col_inc[15:0];
          end
        end
      end
      if (cmd.q_cmp && q_ok) begin
        res_dirty_r <= (fr_rdata != pv_rdata);
        res_color_r <= fr_rdata;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      color_r <= in_pixel_color;
      idx_r   <= in_pixel_index;
    end
    if (cmd.pix_step) begin
      pix_x_r <= pos_x[COL_W-1:0];
      pix_y_r <= pos_y[ROW_W-1:0];
    end
    if (cmd.load_out) begin
      out_dirty_r   <= res_dirty_r;
      out_color_r   <= res_color_r;
      out_written_r <= res_written_r;
    end
  end

  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = cnt_r[ADDR_W-1:0];
    fr_wdata = color_r;
    if (cmd.clear_wr) begin
      fr_we    = 1'b1;
      fr_wdata = RESET_COLOR;
    end else if (cmd.fill_wr) begin
      fr_we = 1'b1;
    end else if (cmd.pix_wr) begin
      fr_we    = res_written_r;
      fr_waddr = pix_addr;
    end
  end

  always_comb begin
    pv_we    = 1'b0;
    pv_waddr = cnt_r[ADDR_W-1:0];
    pv_wdata = '0;
    if (cmd.clear_wr) begin
      pv_we = 1'b1;
    end else if (cmd.q_cmp) begin
      pv_we    = q_ok;
      pv_waddr = idx_r;
      pv_wdata = fr_rdata;
    end
  end

  fbsb_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (idx_r),
    .rdata (fr_rdata)
  );

  fbsb_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (idx_r),
    .rdata (pv_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_dirty     = out_dirty_r;
  assign out_color_out = out_color_r;
  assign out_written   = out_written_r;

endmodule

/* rtl/framebuffer_sprite_blit_diff.sv */
// ----------------------------------------------------------------------------
// framebuffer_sprite_blit_diff: clipped sprite blitter with change tracking
// Frame store, previous-frame store, sprite cursor and per-pixel diff query.
// ----------------------------------------------------------------------------
// Usage. Operation words arrive on the in_ channel (valid/ready); each one
// gives exactly one result word on the out_ channel. Fields that do not
// apply to an operation read as zero. Frame size is set through the cfg_
// channel, which is always ready and should only be written while the
// block is idle.
// Timing. One word is in flight at a time. A sprite begin goes straight to
// the result stage; a sprite pixel or a diff query first passes one clip or
// memory read stage, then the write stage; a fill walks the frame memory
// one pixel per cycle through its single write port. The next word is taken
// once the result is registered and the sequencer is idle again.
// Reset. After rst_n the block runs a clearing pass over the whole store,
// writing the reset colour into the frame store and zero into the previous-frame
// store; in_ready stays low throughout, configuration is still taken.
// Stall. A result waits in the output register while out_ready is low; the
// block finishes the next word's memory work and then holds it until the
// register frees.
// ----------------------------------------------------------------------------
module framebuffer_sprite_blit_diff import fbsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Operation words.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [COLOR_W-1:0]    in_pixel_color,
  input  logic [15:0]           in_sprite_col,
  input  logic [15:0]           in_sprite_row,
  input  logic [15:0]           in_sprite_height,
  input  logic [15:0]           in_sprite_width,
  input  logic [ADDR_W-1:0]     in_pixel_index,
  // Result words.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_dirty,
  output logic [COLOR_W-1:0]    out_color_out,
  output logic                  out_written,
  // Register writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fbsb_cmd_t    cmd;
  fbsb_status_t st;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  // The sequencer owns in_ready and issues one command set per cycle.
  fbsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds every store, the sprite cursor and the output register.
  fbsb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_pixel_color   (in_pixel_color),
    .in_sprite_col    (in_sprite_col),
    .in_sprite_row    (in_sprite_row),
    .in_sprite_height (in_sprite_height),
    .in_sprite_width  (in_sprite_width),
    .in_pixel_index   (in_pixel_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dirty        (out_dirty),
    .out_color_out    (out_color_out),
    .out_written      (out_written)
  );

  // Reset always starts the clearing pass, so no word is taken straight after.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high in the cycle after reset");

  // Only one word is ever in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in flight");

  // The memory write sources are mutually exclusive.
  a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_wr, cmd.fill_wr, cmd.pix_wr, cmd.q_cmp}))
    else $error("conflicting memory write commands");

  // A result is only loaded into a free output register and then shows.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready) ##1 out_valid)
    else $error("result loaded over an untaken word or not shown");

endmodule
